// ===== hdl/tgcl_pkg.sv =====
package tgcl_pkg;

	localparam int TABLE_LEN = 40;
	localparam int ANG_W = 34;
	localparam int XY_W = 34;
	localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [XY_W-1:0] Q30_ONE = 34'sd1073741824;
	localparam logic [28:0] TWO_PI_K_Q16 = 29'd411774832;

	typedef enum logic [1:0] {
		CMODE_ROT = 2'b01,
		CMODE_VEC = 2'b10
	} cmode_t;

	function automatic logic [29:0] atan_entry(input logic [5:0] i);
		logic [29:0] r;
		begin
			case (i)
				6'd0: r = 30'd536870912;
				6'd1: r = 30'd316933406;
				6'd2: r = 30'd167458907;
				6'd3: r = 30'd85004756;
				6'd4: r = 30'd42667331;
				6'd5: r = 30'd21354465;
				6'd6: r = 30'd10679838;
				6'd7: r = 30'd5340245;
				6'd8: r = 30'd2670163;
				6'd9: r = 30'd1335087;
				6'd10: r = 30'd667544;
				6'd11: r = 30'd333772;
				6'd12: r = 30'd166886;
				6'd13: r = 30'd83443;
				6'd14: r = 30'd41721;
				6'd15: r = 30'd20860;
				6'd16: r = 30'd10430;
				6'd17: r = 30'd5215;
				6'd18: r = 30'd2607;
				6'd19: r = 30'd1303;
				6'd20: r = 30'd651;
				6'd21: r = 30'd325;
				6'd22: r = 30'd162;
				6'd23: r = 30'd81;
				6'd24: r = 30'd40;
				6'd25: r = 30'd20;
				6'd26: r = 30'd10;
				6'd27: r = 30'd5;
				6'd28: r = 30'd2;
				6'd29: r = 30'd1;
				default: r = 30'd0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== hdl/tgcl_cordic.sv =====
module tgcl_cordic import tgcl_pkg::*; #(
	parameter int CORDIC_STEPS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input cmode_t mode,
	input logic signed [XY_W-1:0] x_in,
	input logic signed [XY_W-1:0] y_in,
	input logic signed [ANG_W-1:0] z_in,
	output logic done,
	output logic signed [XY_W-1:0] x_out,
	output logic signed [ANG_W-1:0] z_out
);

	localparam int CW = $clog2(CORDIC_STEPS + 1);

	logic busy_q;
	logic [CW-1:0] i_q;
	cmode_t mode_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic signed [XY_W-1:0] xs, ys;
	logic signed [ANG_W-1:0] at;
	logic pos;

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = $signed({{(ANG_W-30){1'b0}}, atan_entry(6'(i_q))});
		pos = (mode_q == CMODE_ROT) ? !z_q[ANG_W-1] : !y_q[XY_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (i_q == CW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode;
			x_q <= x_in;
			y_q <= y_in;
			z_q <= z_in;
		end else if (busy_q) begin
			if (pos == (mode_q == CMODE_ROT)) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
			end
			if (pos)
				z_q <= (mode_q == CMODE_ROT) ? z_q - at : z_q + at;
			else
				z_q <= (mode_q == CMODE_ROT) ? z_q + at : z_q - at;
		end
	end

	assign x_out = x_q;
	assign z_out = z_q;

endmodule

// ===== hdl/tgcl_sqrt.sv =====
module tgcl_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] v_in,
	output logic done,
	output logic [31:0] root
);

	logic busy_q;
	logic [4:0] k_q;
	logic [63:0] v_q, res_q, bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q <= '0;
			end else if (busy_q) begin
				if (k_q == 5'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= v_in;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[31:0];

endmodule

// ===== hdl/track_great_circle_length.sv =====
// Channel | signals                                  | direction
// in      | in_valid, in_stall, latitude, longitude, start_track | into block, in_stall out
// out     | out_valid, out_stall, segment_mm, total_mm, first_point | out of block, out_stall in
// cfg     | cfg_we, cfg_wdata                        | into block
// A request that follows a predecessor runs four rotation passes and one vectoring pass on the one
// shared CORDIC unit, two 32-step root passes and six single steps before out_valid.
// Coincident points skip the root and vectoring passes and the multiply steps.
// A first point's result is valid right after the edge that takes it.
// The input is taken only when idle and the result register is empty; out_stall holds the result.
// Reset clears the state and sets the radius to 6371000.
module track_great_circle_length import tgcl_pkg::*; #(
	parameter int CORDIC_STEPS = 24,
	parameter int TOTAL_WIDTH = 48
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [31:0] latitude,
	input logic signed [31:0] longitude,
	input logic start_track,
	output logic out_valid,
	input logic out_stall,
	output logic [34:0] segment_mm,
	output logic [47:0] total_mm,
	output logic first_point,
	input logic cfg_we,
	input logic [22:0] cfg_wdata
);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_COSA  = 14'b00000000000010,
		S_COSB  = 14'b00000000000100,
		S_HLAT  = 14'b00000000001000,
		S_HLON  = 14'b00000000010000,
		S_PROD  = 14'b00000000100000,
		S_AVAL  = 14'b00000001000000,
		S_SQA   = 14'b00000010000000,
		S_SQB   = 14'b00000100000000,
		S_ATAN  = 14'b00001000000000,
		S_MUL1  = 14'b00010000000000,
		S_MUL2  = 14'b00100000000000,
		S_MUL3  = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	localparam logic [TOTAL_WIDTH-1:0] TMAX = '1;

	state_t state_q;
	logic [22:0] radius_q;
	logic [31:0] prev_lat_q, prev_lon_q, lat_q, lon_q;
	logic have_prev_q;
	logic [TOTAL_WIDTH-1:0] total_q;
	logic signed [XY_W-1:0] cos1_q, cos2_q, hl_q, hn_q, prod_q, a_q;
	logic [31:0] sa_q;
	logic [63:0] p_q, m_q;
	logic [34:0] seg_q;
	logic outv_q, first_q;

	logic c_start, c_done;
	cmode_t c_mode;
	logic signed [XY_W-1:0] c_x, c_y, c_xo;
	logic signed [ANG_W-1:0] c_z, c_zo;
	logic s_start, s_done;
	logic [63:0] s_v;
	logic [31:0] s_root;

	logic [31:0] ang;
	logic neg;
	logic signed [XY_W-1:0] cosv, havv, hsel;
	logic signed [67:0] mprod;
	logic signed [XY_W-1:0] zc;
	logic signed [XY_W-1:0] asum;
	logic accept;

	tgcl_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(c_start), .mode(c_mode),
		.x_in(c_x), .y_in(c_y), .z_in(c_z), .done(c_done),
		.x_out(c_xo), .z_out(c_zo)
	);

	tgcl_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(s_start), .v_in(s_v),
		.done(s_done), .root(s_root)
	);

	assign in_stall = (state_q != S_IDLE) || outv_q;
	assign accept = in_valid && !in_stall;

	// Rotation angle and its quadrant fold, CORDIC and root operands, haversine terms.
	always_comb begin
		unique case (state_q)
			S_COSA: ang = prev_lat_q;
			S_COSB: ang = lat_q;
			S_HLAT: ang = lat_q - prev_lat_q;
			default: ang = lon_q - prev_lon_q;
		endcase
		neg = ang[31] ^ ang[30];
		c_mode = (state_q == S_ATAN) ? CMODE_VEC : CMODE_ROT;
		c_x = (state_q == S_ATAN) ? $signed({2'b00, s_root}) : GAIN_Q30;
		c_y = (state_q == S_ATAN) ? $signed({2'b00, sa_q}) : '0;
		c_z = (state_q == S_ATAN) ? '0 :
			ANG_W'($signed(neg ? ang + 32'h8000_0000 : ang));
		cosv = neg ? -c_xo : c_xo;
		havv = Q30_ONE - cosv;
		if (havv < 0)
			havv = '0;
		if (havv > (Q30_ONE <<< 1))
			havv = Q30_ONE <<< 1;
		havv = havv >>> 1;
		hsel = (state_q == S_PROD) ? cos2_q : hn_q;
		mprod = ((state_q == S_PROD) ? cos1_q : prod_q) * hsel;
		asum = hl_q + XY_W'(mprod >>> 30);
		zc = c_zo;
		if (zc < 0)
			zc = '0;
		if (zc > Q30_ONE)
			zc = Q30_ONE;
		s_v = (state_q == S_SQA) ? (64'(a_q[30:0]) << 30) :
			(64'(31'(Q30_ONE - a_q)) << 30);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			c_start <= 1'b0;
			s_start <= 1'b0;
			radius_q <= 23'd6371000;
			prev_lat_q <= '0;
			prev_lon_q <= '0;
			have_prev_q <= 1'b0;
			total_q <= '0;
			outv_q <= 1'b0;
		end else begin
			c_start <= 1'b0;
			s_start <= 1'b0;
			if (cfg_we)
				radius_q <= cfg_wdata;
			if (outv_q && !out_stall)
				outv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						have_prev_q <= 1'b1;
						if (start_track || !have_prev_q) begin
							prev_lat_q <= latitude;
							prev_lon_q <= longitude;
							total_q <= '0;
							outv_q <= 1'b1;
						end else begin
							state_q <= S_COSA;
							c_start <= 1'b1;
						end
					end
				end
				S_COSA, S_COSB, S_HLAT, S_HLON: begin
					if (c_done) begin
						c_start <= (state_q != S_HLON);
						unique case (state_q)
							S_COSA: state_q <= S_COSB;
							S_COSB: state_q <= S_HLAT;
							S_HLAT: state_q <= S_HLON;
							default: state_q <= S_PROD;
						endcase
					end
				end
				S_PROD: state_q <= S_AVAL;
				S_AVAL: begin
					if (asum <= 0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_SQA;
						s_start <= 1'b1;
					end
				end
				S_SQA: if (s_done) begin
					state_q <= S_SQB;
					s_start <= 1'b1;
				end
				S_SQB: if (s_done) begin
					state_q <= S_ATAN;
					c_start <= 1'b1;
				end
				S_ATAN: if (c_done) state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_MUL3;
				S_MUL3: state_q <= S_OUT;
				S_OUT: begin
					if (total_q > TMAX - TOTAL_WIDTH'(seg_q))
						total_q <= TMAX;
					else
						total_q <= total_q + TOTAL_WIDTH'(seg_q);
					prev_lat_q <= lat_q;
					prev_lon_q <= lon_q;
					outv_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; the previous point is replaced only when the result is formed.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			lat_q <= latitude;
			lon_q <= longitude;
			first_q <= start_track || !have_prev_q;
			seg_q <= '0;
		end
		if (c_done) begin
			unique case (state_q)
				S_COSA: cos1_q <= cosv;
				S_COSB: cos2_q <= cosv;
				S_HLAT: hl_q <= havv;
				S_HLON: hn_q <= havv;
				default: ;
			endcase
		end
		if (state_q == S_PROD)
			prod_q <= XY_W'(mprod >>> 30);
		if (state_q == S_AVAL)
			a_q <= (asum > Q30_ONE) ? Q30_ONE : asum;
		if (s_done && state_q == S_SQA)
			sa_q <= s_root;
		if (state_q == S_ATAN && c_done)
			p_q <= 64'(radius_q) * 64'(zc <<< 1);
		if (state_q == S_MUL1)
			m_q <= 64'(p_q[53:24]) * 64'(TWO_PI_K_Q16);
		if (state_q == S_MUL2)
			m_q <= m_q + ((64'(p_q[23:0]) * 64'(TWO_PI_K_Q16)) >> 24);
		if (state_q == S_MUL3)
			seg_q <= 35'(m_q >> 24);
	end

	assign segment_mm = seg_q;
	assign total_mm = 48'(total_q);
	assign first_point = first_q;
	assign out_valid = outv_q;

	a_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && first_point) |-> (segment_mm == '0))
		else $error("first point with nonzero segment");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(total_mm)))
		else $error("result changed while stalled");

endmodule
